// ===== hdl/smbu_pkg.sv =====
package smbu_pkg;
   localparam int MaxLen = 256;
   localparam int AddrW = $clog2(MaxLen);
   localparam int LenW = AddrW + 1;

   typedef enum logic [4:0] {
      ST_LOAD, ST_PCHK, ST_PCHK_W, ST_AT_RD, ST_AT_CHK, ST_DOM_RD, ST_DOM_CHK,
      ST_USR_RD, ST_USR_CHK, ST_SRV_RD, ST_SRV_CHK, ST_PRT_RD, ST_PRT_CHK,
      ST_SHR_RD, ST_SHR_CHK, ST_PTH_RD, ST_PTH_CHK, ST_FIN,
      ST_IDLE, ST_F0_RD, ST_F0_W, ST_F1_W, ST_F2_W, ST_OUT
   } state_type;

   localparam logic [1:0] StatOk = 2'd0;
   localparam logic [1:0] StatNotSmb = 2'd1;
   localparam logic [1:0] StatTooLong = 2'd2;
   localparam logic [1:0] StatNotReady = 2'd3;

   localparam logic [1:0] PhLoad = 2'd0;
   localparam logic [1:0] PhFetch = 2'd1;
   localparam logic [1:0] PhDone = 2'd2;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c[3:0];
      return 4'd9 + {1'b0, c[2:0]};
   endfunction
endpackage

// ===== hdl/smbu_ram.sv =====
module smbu_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/smb_url_component_splitter.sv =====
// Append transfer: the byte is written into the buffer on acceptance. The final append
// starts a parse, not ready meanwhile: a prefix check, then a RAM read and a compare per
// scanned byte; the credential scans may walk the rest three times.
// Fetch transfer: accept, reads of p, p+1, p+2 and decode, then the result for data;
// a status-only answer goes from accept straight to the result, which waits out any stall on the result side.
// Reset (synchronous, active high) returns to loading; the buffer is not cleared.
module smb_url_component_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_in
   input  logic        req_tuser,   // kind
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // data_byte[7:0], has_data, all_done, status[1:0], 0
   output logic [2:0]  rsp_tuser,   // part
   output logic        rsp_tlast    // part_last
);
   localparam int LW = smbu_pkg::LenW;
   localparam int AW = smbu_pkg::AddrW;

   smbu_pkg::state_type st_ff, st_in;
   logic [LW-1:0] len_ff, len_in;
   logic ovf_ff, ovf_in;
   logic [1:0] ph_ff, ph_in, err_ff, err_in;
   logic [LW-1:0] bnd_ff [14];
   logic [LW-1:0] bnd_in [14];
   logic [LW-1:0] rp_ff, rp_in, idx_ff, idx_in, at_ff, at_in;
   logic [2:0] cp_ff, cp_in;
   logic [7:0] c0_ff, c0_in, c1_ff, c1_in;
   logic [7:0] o_byte_ff, o_byte_in;
   logic [2:0] o_part_ff, o_part_in;
   logic o_has_ff, o_has_in, o_last_ff, o_last_in, o_done_ff, o_done_in;
   logic [1:0] o_stat_ff, o_stat_in;
   logic found_ff, found_in;

   logic wr_en;
   logic [AW-1:0] rd_addr;
   logic [7:0] rd_data;
   logic [LW-1:0] rd_idx;

   smbu_ram #(.Width(8), .Depth(smbu_pkg::MaxLen)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(len_in[AW-1:0] - AW'(1)),
      .wr_data(req_tdata), .rd_addr(rd_addr), .rd_data(rd_data));

   assign rd_addr = rd_idx[AW-1:0];

   // first non-empty part at or after p, 7 when none
   function automatic logic [2:0] next_part(input logic [3:0] p,
                                            input logic [LW-1:0] b [14]);
      logic [3:0] r;
      r = 4'd7;
      for (int k = 6; k >= 0; k--) begin
         if (4'(k) >= p && b[2*k] < b[2*k+1]) r = 4'(k);
      end
      return r[2:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= smbu_pkg::ST_LOAD;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         ph_ff <= smbu_pkg::PhLoad;
         err_ff <= '0;
         cp_ff <= '0;
         rp_ff <= '0;
         for (int k = 0; k < 14; k++) bnd_ff[k] <= '0;
      end else begin
         st_ff <= st_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         ph_ff <= ph_in;
         err_ff <= err_in;
         cp_ff <= cp_in;
         rp_ff <= rp_in;
         bnd_ff <= bnd_in;
      end
      idx_ff <= idx_in;
      at_ff <= at_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      found_ff <= found_in;
      o_byte_ff <= o_byte_in;
      o_part_ff <= o_part_in;
      o_has_ff <= o_has_in;
      o_last_ff <= o_last_in;
      o_done_ff <= o_done_in;
      o_stat_ff <= o_stat_in;
   end

   logic [LW-1:0] six_n;
   logic [LW:0] e_end;
   logic [LW-1:0] pe;
   logic [2:0] np;
   logic [7:0] ch;

   always_comb begin
      st_in = st_ff; len_in = len_ff; ovf_in = ovf_ff; ph_in = ph_ff; err_in = err_ff;
      bnd_in = bnd_ff; rp_in = rp_ff; idx_in = idx_ff; at_in = at_ff; cp_in = cp_ff;
      c0_in = c0_ff; c1_in = c1_ff; found_in = found_ff;
      o_byte_in = o_byte_ff; o_part_in = o_part_ff; o_has_in = o_has_ff;
      o_last_in = o_last_ff; o_done_in = o_done_ff; o_stat_in = o_stat_ff;
      req_tready = 1'b0; wr_en = 1'b0; rd_idx = idx_ff;
      six_n = len_ff;  // end of URL in absolute index
      ch = rd_data;
      pe = bnd_ff[2*cp_ff+1];
      e_end = {1'b0, pe};
      np = 3'd7;
      unique case (st_ff)
         smbu_pkg::ST_LOAD, smbu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && !req_tuser) begin
               if (ph_ff != smbu_pkg::PhLoad) begin
                  len_in = '0; ovf_in = 1'b0; err_in = '0;
               end
               ph_in = smbu_pkg::PhLoad;
               if (len_in < LW'(smbu_pkg::MaxLen)) begin
                  len_in = len_in + LW'(1);
                  wr_en = 1'b1;
               end else ovf_in = 1'b1;
               st_in = smbu_pkg::ST_LOAD;
               if (req_tlast) begin
                  for (int k = 0; k < 14; k++) bnd_in[k] = '0;
                  rp_in = '0; cp_in = '0;
                  idx_in = '0;
                  st_in = smbu_pkg::ST_PCHK;
               end
            end else if (req_tvalid) begin
               o_part_in = '0; o_byte_in = '0; o_has_in = 1'b0; o_last_in = 1'b0;
               st_in = smbu_pkg::ST_OUT;
               if (ph_ff == smbu_pkg::PhLoad) begin
                  o_done_in = 1'b0; o_stat_in = smbu_pkg::StatNotReady;
               end else if (ph_ff != smbu_pkg::PhFetch) begin
                  o_done_in = 1'b1; o_stat_in = err_ff;
               end else begin
                  o_done_in = 1'b0; o_stat_in = smbu_pkg::StatOk;
                  idx_in = rp_ff;
                  st_in = smbu_pkg::ST_F0_RD;
               end
            end
         end
         // prefix check: issue reads of bytes 0..5 one after the other
         smbu_pkg::ST_PCHK: begin
            if (ovf_ff) begin
               err_in = smbu_pkg::StatTooLong; ph_in = smbu_pkg::PhDone;
               st_in = smbu_pkg::ST_IDLE;
            end else if (len_ff <= LW'(6)) begin
               err_in = smbu_pkg::StatNotSmb; ph_in = smbu_pkg::PhDone;
               st_in = smbu_pkg::ST_IDLE;
            end else st_in = smbu_pkg::ST_PCHK_W;
         end
         smbu_pkg::ST_PCHK_W: begin
            found_in = 1'b1;
            unique case (idx_ff[2:0])
               3'd0: found_in = (ch == 8'h73 || ch == 8'h53);
               3'd1: found_in = (ch == 8'h6d || ch == 8'h4d);
               3'd2: found_in = (ch == 8'h62 || ch == 8'h42);
               3'd3: found_in = (ch == 8'h3a);
               default: found_in = (ch == 8'h2f);
            endcase
            if (!found_in) begin
               err_in = smbu_pkg::StatNotSmb; ph_in = smbu_pkg::PhDone;
               st_in = smbu_pkg::ST_IDLE;
            end else if (idx_ff == LW'(5)) begin
               err_in = '0;
               for (int k = 0; k < 14; k++) bnd_in[k] = LW'(6);
               idx_in = LW'(6); at_in = LW'(6);
               st_in = smbu_pkg::ST_AT_RD;
            end else begin
               idx_in = idx_ff + LW'(1);
               st_in = smbu_pkg::ST_PCHK;
            end
         end
         // each scan: _RD waits for read data, _CHK compares
         smbu_pkg::ST_AT_RD: st_in = (idx_ff == six_n) ? smbu_pkg::ST_SRV_RD
                                                       : smbu_pkg::ST_AT_CHK;
         smbu_pkg::ST_AT_CHK: begin
            if (ch == 8'h40) begin
               at_in = idx_ff; idx_in = LW'(6);
               st_in = smbu_pkg::ST_DOM_RD;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_AT_RD;
            end
            // no '@' at all: the server starts right after the prefix
            if (st_in == smbu_pkg::ST_AT_RD && idx_in == six_n) begin
               idx_in = LW'(6); st_in = smbu_pkg::ST_SRV_RD;
            end
         end
         smbu_pkg::ST_DOM_RD: begin
            if (idx_ff == at_ff) begin
               idx_in = LW'(6); st_in = smbu_pkg::ST_USR_RD;
            end else st_in = smbu_pkg::ST_DOM_CHK;
         end
         smbu_pkg::ST_DOM_CHK: begin
            if (ch == 8'h3b) begin
               bnd_in[1] = idx_ff; bnd_in[2] = idx_ff + LW'(1);
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_USR_RD;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_DOM_RD;
            end
         end
         smbu_pkg::ST_USR_RD: begin
            if (st_ff == smbu_pkg::ST_USR_RD && idx_ff == at_ff) begin
               bnd_in[3] = idx_ff;
               bnd_in[6] = at_ff + LW'(1); idx_in = at_ff + LW'(1);
               st_in = smbu_pkg::ST_SRV_RD;
            end else st_in = smbu_pkg::ST_USR_CHK;
         end
         smbu_pkg::ST_USR_CHK: begin
            if (ch == 8'h3a) begin
               bnd_in[3] = idx_ff; bnd_in[4] = idx_ff + LW'(1); bnd_in[5] = at_ff;
               bnd_in[6] = at_ff + LW'(1); idx_in = at_ff + LW'(1);
               st_in = smbu_pkg::ST_SRV_RD;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_USR_RD;
            end
         end
         smbu_pkg::ST_SRV_RD: begin
            if (idx_ff == six_n) begin
               bnd_in[7] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else st_in = smbu_pkg::ST_SRV_CHK;
         end
         smbu_pkg::ST_SRV_CHK: begin
            if (ch == 8'h3a) begin
               bnd_in[7] = idx_ff; bnd_in[8] = idx_ff + LW'(1);
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_PRT_RD;
            end else if (ch == 8'h2f) begin
               bnd_in[7] = idx_ff; bnd_in[10] = idx_ff + LW'(1);
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_SHR_RD;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_SRV_RD;
            end
         end
         smbu_pkg::ST_PRT_RD: begin
            if (idx_ff == six_n) begin
               bnd_in[9] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else st_in = smbu_pkg::ST_PRT_CHK;
         end
         smbu_pkg::ST_PRT_CHK: begin
            if (ch == 8'h2f) begin
               bnd_in[9] = idx_ff; bnd_in[10] = idx_ff + LW'(1);
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_SHR_RD;
            end else if (ch == 8'h3f) begin
               bnd_in[9] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_PRT_RD;
            end
         end
         smbu_pkg::ST_SHR_RD: begin
            if (idx_ff == six_n) begin
               bnd_in[11] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else st_in = smbu_pkg::ST_SHR_CHK;
         end
         smbu_pkg::ST_SHR_CHK: begin
            if (ch == 8'h2f) begin
               bnd_in[11] = idx_ff; bnd_in[12] = idx_ff + LW'(1);
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_PTH_RD;
            end else if (ch == 8'h3f) begin
               bnd_in[11] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_SHR_RD;
            end
         end
         smbu_pkg::ST_PTH_RD: begin
            if (idx_ff == six_n) begin
               bnd_in[13] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else st_in = smbu_pkg::ST_PTH_CHK;
         end
         smbu_pkg::ST_PTH_CHK: begin
            if (ch == 8'h3f) begin
               bnd_in[13] = idx_ff; st_in = smbu_pkg::ST_FIN;
            end else begin
               idx_in = idx_ff + LW'(1); st_in = smbu_pkg::ST_PTH_RD;
            end
         end
         smbu_pkg::ST_FIN: begin
            np = next_part(4'd0, bnd_ff);
            st_in = smbu_pkg::ST_IDLE;
            if (np < 3'd7) begin
               cp_in = np; rp_in = bnd_ff[2*np]; ph_in = smbu_pkg::PhFetch;
            end else begin
               cp_in = '0; rp_in = '0; ph_in = smbu_pkg::PhDone;
            end
         end
         // fetch: read p, p+1, p+2 in turn
         smbu_pkg::ST_F0_RD: begin
            c0_in = rd_data; rd_idx = rp_ff + LW'(1); st_in = smbu_pkg::ST_F0_W;
         end
         smbu_pkg::ST_F0_W: begin
            c1_in = rd_data; rd_idx = rp_ff + LW'(2);
            st_in = smbu_pkg::ST_F1_W;
         end
         smbu_pkg::ST_F1_W: begin
            rd_idx = rp_ff + LW'(2); st_in = smbu_pkg::ST_F2_W;
         end
         smbu_pkg::ST_F2_W: begin
            if (c0_ff == 8'h25 && ({1'b0, rp_ff} + (LW+1)'(2)) < e_end &&
                smbu_pkg::is_hex(c1_ff) && smbu_pkg::is_hex(rd_data)) begin
               o_byte_in = {smbu_pkg::hex_val(c1_ff), smbu_pkg::hex_val(rd_data)};
               idx_in = rp_ff + LW'(3);
            end else begin
               o_byte_in = c0_ff;
               idx_in = rp_ff + LW'(1);
            end
            o_part_in = cp_ff; o_has_in = 1'b1;
            if (idx_in >= pe) begin
               o_last_in = 1'b1;
               np = next_part({1'b0, cp_ff} + 4'd1, bnd_ff);
               if (np < 3'd7) begin
                  cp_in = np; rp_in = bnd_ff[2*np];
               end else begin
                  cp_in = '0; rp_in = '0; ph_in = smbu_pkg::PhDone; err_in = '0;
                  o_done_in = 1'b1;
               end
            end else rp_in = idx_in;
            st_in = smbu_pkg::ST_OUT;
         end
         smbu_pkg::ST_OUT: if (rsp_tready) st_in = smbu_pkg::ST_IDLE;
         default: st_in = smbu_pkg::ST_IDLE;
      endcase
      // scan read address follows idx; fetch reads are set above, the first one below
      if (st_in == smbu_pkg::ST_PCHK_W || st_in == smbu_pkg::ST_AT_CHK ||
          st_in == smbu_pkg::ST_DOM_CHK || st_in == smbu_pkg::ST_USR_CHK ||
          st_in == smbu_pkg::ST_SRV_CHK || st_in == smbu_pkg::ST_PRT_CHK ||
          st_in == smbu_pkg::ST_SHR_CHK || st_in == smbu_pkg::ST_PTH_CHK)
         rd_idx = idx_ff;
      if (st_ff == smbu_pkg::ST_IDLE && st_in == smbu_pkg::ST_F0_RD) rd_idx = rp_ff;
   end

   assign rsp_tvalid = (st_ff == smbu_pkg::ST_OUT);
   assign rsp_tdata = {4'b0, o_stat_ff, o_done_ff, o_has_ff, o_byte_ff};
   assign rsp_tuser = o_part_ff;
   assign rsp_tlast = o_last_ff;
endmodule

// ===== tb/smb_url_component_splitter_tb.sv =====
`timescale 1ns / 1ps

module smb_url_component_splitter_tb;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic [2:0] part;
      logic [7:0] data_byte;
      logic       has_data;
      logic       part_last;
      logic       all_done;
      logic [1:0] status;
   } fetch_result_type;

   // Mirrors the splitter: holds its own copy of the URL store and part bounds,
   // and queues the expected transfer for every fetch.
   class url_splitter_scoreboard;
      logic [7:0]       url_mem[smbu_pkg::MaxLen];
      int unsigned      url_len;
      bit               overflowed;
      int unsigned      bounds[14];
      int unsigned      rd_ptr;
      int unsigned      cur_part;
      logic [1:0]       phase;
      logic [1:0]       err;
      fetch_result_type pending[$];
      int               errors;

      function new();
         url_len = 0; overflowed = 0; rd_ptr = 0; cur_part = 0;
         phase = smbu_pkg::PhLoad; err = smbu_pkg::StatOk; errors = 0;
         foreach (bounds[i]) bounds[i] = 0;
         foreach (url_mem[i]) url_mem[i] = 8'h00;
      endfunction

      function logic [7:0] at(int unsigned i);
         return (i < smbu_pkg::MaxLen) ? url_mem[i] : 8'h00;
      endfunction

      function bit hexish(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      function int unsigned nibble(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         return 9 + (c & 7);
      endfunction

      function int unsigned first_part_from(int unsigned p);
         while (p < 7 && !(bounds[2*p] < bounds[2*p+1])) p++;
         return p;
      endfunction

      function void split_url();
         int unsigned n, i, j, a;
         int unsigned b[14];
         logic [7:0] c0, c1, c2;
         foreach (b[k]) b[k] = 0;
         foreach (bounds[k]) bounds[k] = 0;
         rd_ptr = 0; cur_part = 0;
         c0 = at(0); c1 = at(1); c2 = at(2);
         if (overflowed) begin
            err = smbu_pkg::StatTooLong; phase = smbu_pkg::PhDone; return;
         end
         if (url_len <= 6 || !(c0 == "s" || c0 == "S") || !(c1 == "m" || c1 == "M") ||
             !(c2 == "b" || c2 == "B") || at(3) != ":" || at(4) != "/" || at(5) != "/") begin
            err = smbu_pkg::StatNotSmb; phase = smbu_pkg::PhDone; return;
         end
         err = smbu_pkg::StatOk;
         n = url_len - 6;
         // credentials end at the first '@'
         for (a = 0; a < n; a++) begin
            if (at(6+a) == "@") begin
               for (j = 0; j < a; j++)
                  if (at(6+j) == ";") begin b[1] = j; b[2] = j + 1; break; end
               for (j = b[2]; j <= a; j++)
                  if (j == a || at(6+j) == ":") begin
                     b[3] = j;
                     if (j < a) begin b[4] = j + 1; b[5] = a; end
                     break;
                  end
               b[6] = a + 1;
               break;
            end
         end
         for (i = b[6]; i <= n; i++) begin
            if (i == n || at(6+i) == "/" || at(6+i) == ":") begin
               b[7] = i;
               if (i < n) begin
                  if (at(6+i) == ":") begin
                     b[8] = i + 1;
                     for (j = b[8]; j <= n; j++)
                        if (j == n || at(6+j) == "/" || at(6+j) == "?") begin
                           b[9] = j;
                           if (j < n && at(6+j) == "/") b[10] = j + 1;
                           break;
                        end
                  end else b[10] = i + 1;
               end
               break;
            end
         end
         if (b[10] > 0)
            for (i = b[10]; i <= n; i++)
               if (i == n || at(6+i) == "/" || at(6+i) == "?") begin
                  b[11] = i;
                  if (i < n && at(6+i) == "/") b[12] = i + 1;
                  break;
               end
         if (b[12] > 0)
            for (i = b[12]; i <= n; i++)
               if (i == n || at(6+i) == "?") begin b[13] = i; break; end
         foreach (b[k]) bounds[k] = b[k] + 6;
         cur_part = first_part_from(0);
         if (cur_part < 7) begin
            rd_ptr = bounds[2*cur_part]; phase = smbu_pkg::PhFetch;
         end else phase = smbu_pkg::PhDone;
      endfunction

      // Note an accepted input transfer.
      function void note_request(bit kind, logic [7:0] ch, bit last);
         fetch_result_type r;
         int unsigned p, e, np;
         logic [7:0] c;
         if (!kind) begin
            if (phase != smbu_pkg::PhLoad) begin
               url_len = 0; overflowed = 0; phase = smbu_pkg::PhLoad;
               err = smbu_pkg::StatOk;
            end
            if (url_len < smbu_pkg::MaxLen) url_mem[url_len++] = ch;
            else overflowed = 1;
            if (last) split_url();
            return;
         end
         r = '0;
         if (phase == smbu_pkg::PhLoad) begin
            r.status = smbu_pkg::StatNotReady;
         end else if (phase != smbu_pkg::PhFetch || cur_part >= 7) begin
            r.all_done = 1; r.status = err;
         end else begin
            p = rd_ptr; e = bounds[2*cur_part+1]; c = at(p);
            if (c == "%" && p + 2 < e && hexish(at(p+1)) && hexish(at(p+2))) begin
               c = 8'(16 * nibble(at(p+1)) + nibble(at(p+2)));
               p += 3;
            end else p += 1;
            r.part = 3'(cur_part); r.data_byte = c; r.has_data = 1;
            if (p >= e) begin
               r.part_last = 1;
               np = first_part_from(cur_part + 1);
               cur_part = np;
               if (np < 7) rd_ptr = bounds[2*np];
               else begin
                  rd_ptr = 0; cur_part = 0; phase = smbu_pkg::PhDone; r.all_done = 1;
               end
            end else rd_ptr = p;
         end
         pending.push_back(r);
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      endtask

      // Check a result transfer against the oldest expectation.
      task check_result(logic [15:0] tdata, logic [2:0] tuser, logic tlast);
         fetch_result_type w;
         if (pending.size() == 0) begin
            report("unexpected result tdata", tdata, 0);
            return;
         end
         w = pending.pop_front();
         if (tuser !== w.part) report("part", tuser, w.part);
         if (tdata[7:0] !== w.data_byte) report("data_byte", tdata[7:0], w.data_byte);
         if (tdata[8] !== w.has_data) report("has_data", tdata[8], w.has_data);
         if (tdata[9] !== w.all_done) report("all_done", tdata[9], w.all_done);
         if (tdata[11:10] !== w.status) report("status", tdata[11:10], w.status);
         if (tlast !== w.part_last) report("part_last", tlast, w.part_last);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   url_splitter_scoreboard sb;
   int  cycles;
   bit  long_hold;   // forces the receiver to hold off
   bit  rx_idle_ok;  // allows random receiver idling

   smb_url_component_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge; note inputs, check results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Cycle limit: end the run if it stalls.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: draw a wait per transfer, with quiet stretches and a long hold.
   initial begin
      int waits;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            @(negedge clock);
         end else begin
            waits = rx_idle_ok ? $urandom_range(0, 12) : 0;
            if ($urandom_range(0, 3) == 0) waits = 0;
            if (waits > 0) begin
               rsp_tready <= 0;
               repeat (waits) @(negedge clock);
            end
            rsp_tready <= 1;
            @(negedge clock);
            while (!(rsp_tvalid && rsp_tready) && !long_hold) @(negedge clock);
         end
      end
   end

   // Offer one transfer after an optional gap; hold it until accepted.
   task automatic send(bit kind, logic [7:0] ch, bit last, bit gaps);
      int waits;
      waits = gaps ? $urandom_range(0, 12) : 0;
      if (waits > 0) begin
         req_tvalid <= 0;
         repeat (waits) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= ch;
      req_tlast  <= last;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_url(string s, bit gaps);
      for (int i = 0; i < s.len(); i++) send(0, s[i], i == s.len() - 1, gaps);
   endtask

   task automatic drain_fetches(int count, bit gaps);
      repeat (count) send(1, 8'($urandom_range(0, 255)), $urandom_range(0, 1), gaps);
   endtask

   // Pause until every expected result has arrived.
   task automatic wait_empty();
      req_tvalid <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] rand_url_char();
      int unsigned k;
      string pool;
      pool = "@;:/?%%0aF9gZ";
      k = $urandom_range(0, 9);
      if (k < 4) return pool[$urandom_range(0, pool.len() - 1)];
      if (k < 5) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h61, 8'h7a));
   endfunction

   function automatic string rand_piece(int maxlen);
      string s;
      int n;
      s = "";
      n = $urandom_range(0, maxlen);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) s = {s, "%", "4", "1"};
         else s = {s, string'(rand_url_char())};
      end
      return s;
   endfunction

   // Build a mostly well-formed URL with random content and occasional noise.
   function automatic string rand_url();
      string s, pre;
      int k;
      k = $urandom_range(0, 9);
      pre = ($urandom_range(0, 1) != 0) ? "smb://" : "SmB://";
      if (k == 0) pre = "smx://";
      if (k == 1) return pre;
      s = pre;
      if ($urandom_range(0, 1) != 0)
         s = {s, rand_piece(3), ";", rand_piece(3), ":", rand_piece(3), "@"};
      s = {s, rand_piece(6)};
      if ($urandom_range(0, 1) != 0) s = {s, ":", rand_piece(3)};
      if ($urandom_range(0, 2) != 0) s = {s, "/", rand_piece(5)};
      if ($urandom_range(0, 1) != 0) s = {s, "/", rand_piece(8)};
      if ($urandom_range(0, 2) == 0) s = {s, "?", rand_piece(3)};
      return s;
   endfunction

   initial begin
      int items;
      string u;
      sb = new();
      long_hold = 0;
      rx_idle_ok = 1;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      req_tlast = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: fetch while loading, escapes, credentials, bad prefix, empty rest.
      send(1, 8'hff, 1, 0);
      send_url("SMB://d;u:p@s%41:1/sh/pa%2f%zz?q", 0);
      drain_fetches(24, 0);
      send_url("smb:/x", 0);
      drain_fetches(2, 0);
      send_url("smb://", 0);
      drain_fetches(1, 0);
      send(0, 8'h00, 0, 0);
      send(0, 8'hff, 1, 0);
      drain_fetches(1, 0);
      wait_empty();

      // Too long: one byte beyond the buffer, then two fetches.
      for (int i = 0; i <= smbu_pkg::MaxLen; i++)
         send(0, 8'($urandom_range(0, 255)), i == smbu_pkg::MaxLen, 0);
      drain_fetches(2, 0);
      wait_empty();

      // Long receiver hold while the sender keeps offering fetches.
      send_url("smb://server/share/some/longer/path", 0);
      long_hold = 1;
      fork
         drain_fetches(30, 0);
         begin
            repeat (300) @(negedge clock);
            long_hold = 0;
         end
      join
      wait_empty();

      // Random URLs, each followed by a random number of fetches.
      items = 0;
      while (items < 350) begin
         rx_idle_ok = ($urandom_range(0, 4) != 0);
         u = rand_url();
         send_url(u, $urandom_range(0, 1));
         items += u.len();
         k_fetch: begin
            int nf;
            nf = $urandom_range(0, u.len() + 2);
            drain_fetches(nf, $urandom_range(0, 1));
            items += nf;
         end
         if ($urandom_range(0, 9) == 0) wait_empty();
      end

      req_tvalid <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.pending.size() == 0 && sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
